/* rtl/aest_pkg.sv */
// ----------------------------------------------------------------------------
// aest_pkg: shared types and constants for the antagonistic spring block
// Fixed-point constants, register indexes and the structs passed between
// the spring lanes and the top level.
// ----------------------------------------------------------------------------
package aest_pkg;

  // Taylor series length and pipeline depths
  localparam int TAYLOR_TERMS = 12;
  localparam int EXP_STAGES   = 2 * TAYLOR_TERMS;
  localparam int LANE_LAT     = 13 + EXP_STAGES;

  // ln2 in unsigned Q.32 and 1.0 in Q.32
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // floor(2^52 / ln2_q32), used to estimate the ln2 multiple
  localparam logic [63:0] RECIP_LN2_W = (64'd1 << 52) / 64'hB172_17F8;
  localparam logic [20:0] RECIP_LN2   = RECIP_LN2_W[20:0];

  // saturation bound of e^|x| in unsigned Q16.32
  localparam logic [47:0] EXP_MAX = 48'hFFFF_FFFF_FFFF;

  // configuration register indexes
  localparam logic [2:0] REG_A_COEFF = 3'd0;
  localparam logic [2:0] REG_B_COEFF = 3'd1;
  localparam logic [2:0] REG_GAIN    = 3'd2;
  localparam logic [2:0] REG_RATE    = 3'd3;
  localparam logic [2:0] REG_LIMIT   = 3'd4;

  typedef struct packed {
    logic [31:0] lo_coef;
    logic [31:0] hi_coef;
    logic [23:0] gain;
    logic [23:0] rate;
    logic [26:0] limit;
  } spring_cfg_t;

  typedef struct packed {
    logic signed [48:0] torque;
    logic        [56:0] stiffness;
    logic               ovf;
  } lane_res_t;

endpackage

/* rtl/aest_exp.sv */
// ----------------------------------------------------------------------------
// aest_exp: pipelined Taylor evaluation of e^r
// Two stages per term: term times r, then divide by the term index through
// an exact reciprocal multiply. Sum in Q.32 after 2*TAYLOR_TERMS stages.
// ----------------------------------------------------------------------------
module aest_exp (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] arg,
  output logic [33:0] sum
);
  import aest_pkg::*;

  logic [32:0] pa [1:TAYLOR_TERMS];
  logic [31:0] ra [1:TAYLOR_TERMS];
  logic [33:0] sa [1:TAYLOR_TERMS];
  logic [32:0] tb [1:TAYLOR_TERMS];
  logic [31:0] rb [1:TAYLOR_TERMS];
  logic [33:0] sb [1:TAYLOR_TERMS];

  for (genvar i = 1; i <= TAYLOR_TERMS; i++) begin : g_term
    localparam logic [63:0] MW = ((64'd1 << 37) + 64'(i) - 64'd1) / 64'(i);
    logic [70:0] quo;

    if (i == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          pa[i] <= {1'b0, arg};
          ra[i] <= arg;
          sa[i] <= {1'b0, ONE_Q32};
        end
      end
    end else begin : g_next
      logic [64:0] prod;
      assign prod = 65'(tb[i-1]) * 65'(rb[i-1]);
      always_ff @(posedge clk) begin
        if (en) begin
          pa[i] <= prod[64:32];
          ra[i] <= rb[i-1];
          sa[i] <= sb[i-1] + 34'(tb[i-1]);
        end
      end
    end

    // exact floor(pa / i) for pa below 2^33
    assign quo = 71'(pa[i]) * 71'(MW[37:0]);

    always_ff @(posedge clk) begin
      if (en) begin
        tb[i] <= quo[69:37];
        rb[i] <= ra[i];
        sb[i] <= sa[i];
      end
    end
  end

  assign sum = sb[TAYLOR_TERMS] + 34'(tb[TAYLOR_TERMS]);

endmodule

/* rtl/aest_spring.sv */
// ----------------------------------------------------------------------------
// aest_spring: one exponential spring lane
// Clamp deflection, scale by the rate, split into n*ln2 + r, evaluate both
// exponentials, then form torque and stiffness through split products.
// ----------------------------------------------------------------------------
module aest_spring (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [31:0]   motor,
  input  logic signed [31:0]   link,
  input  aest_pkg::spring_cfg_t cfg,
  output aest_pkg::lane_res_t  res
);
  import aest_pkg::*;

  // stage 1: deflection and clamp
  logic signed [32:0] d, lim_s, dc;
  logic        [26:0] s1_mag;
  logic               s1_neg;

  always_comb begin
    d     = 33'(motor) - 33'(link);
    lim_s = $signed({6'b0, cfg.limit});
    if (d > lim_s)       dc = lim_s;
    else if (d < -lim_s) dc = -lim_s;
    else                 dc = d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg <= dc[32];
      s1_mag <= dc[32] ? 27'(-dc) : dc[26:0];
    end
  end

  // stage 2: exponent magnitude
  logic [50:0] xm_full;
  logic [42:0] s2_xm;
  logic        s2_neg;
  assign xm_full = 51'(s1_mag) * 51'(cfg.rate);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_xm  <= xm_full[50:8];
      s2_neg <= s1_neg;
    end
  end

  // stage 3: estimate of the ln2 multiple, low by at most one
  logic [43:0] nq;
  logic [11:0] s3_nest;
  logic [42:0] s3_xm;
  logic        s3_neg;
  assign nq = 44'(s2_xm[42:20]) * 44'(RECIP_LN2);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nest <= nq[43:32];
      s3_xm   <= s2_xm;
      s3_neg  <= s2_neg;
    end
  end

  // stage 4: raw remainder
  logic [43:0] nl, rdiff;
  logic [32:0] s4_r0;
  logic [11:0] s4_nest;
  logic        s4_neg;
  assign nl    = 44'(s3_nest) * 44'(LN2_Q32);
  assign rdiff = 44'(s3_xm) - nl;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r0   <= rdiff[32:0];
      s4_nest <= s3_nest;
      s4_neg  <= s3_neg;
    end
  end

  // stage 5: correct the estimate
  logic [32:0] r_fix;
  logic [31:0] s5_r, s5_rc;
  logic [11:0] s5_n;
  logic        s5_neg;
  assign r_fix = s4_r0 - {1'b0, LN2_Q32};

  always_ff @(posedge clk) begin
    if (en) begin
      s5_neg <= s4_neg;
      if (s4_r0 >= {1'b0, LN2_Q32}) begin
        s5_n  <= s4_nest + 12'd1;
        s5_r  <= r_fix[31:0];
        s5_rc <= LN2_Q32 - r_fix[31:0];
      end else begin
        s5_n  <= s4_nest;
        s5_r  <= s4_r0[31:0];
        s5_rc <= LN2_Q32 - s4_r0[31:0];
      end
    end
  end

  // exponentials, with the shift count and sign carried alongside
  logic [33:0] sum_up, sum_dn;
  logic [11:0] n_dly   [EXP_STAGES];
  logic        neg_dly [EXP_STAGES];

  aest_exp u_exp_up (.clk(clk), .en(en), .arg(s5_r),  .sum(sum_up));
  aest_exp u_exp_dn (.clk(clk), .en(en), .arg(s5_rc), .sum(sum_dn));

  always_ff @(posedge clk) begin
    if (en) begin
      n_dly[0]   <= s5_n;
      neg_dly[0] <= s5_neg;
      for (int k = 1; k < EXP_STAGES; k++) begin
        n_dly[k]   <= n_dly[k-1];
        neg_dly[k] <= neg_dly[k-1];
      end
    end
  end

  // stage 6: scale by 2^n and 2^-(n+1)
  logic [11:0] n6;
  logic [48:0] up_sh;
  logic [47:0] s6_up, s6_dn;
  logic        s6_ovf, s6_neg;
  assign n6    = n_dly[EXP_STAGES-1];
  assign up_sh = 49'(sum_up) << n6[3:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s6_neg <= neg_dly[EXP_STAGES-1];
      if (n6 >= 12'd16) begin
        s6_up  <= EXP_MAX;
        s6_ovf <= 1'b1;
      end else if (up_sh > 49'(EXP_MAX)) begin
        s6_up  <= EXP_MAX;
        s6_ovf <= 1'b1;
      end else begin
        s6_up  <= up_sh[47:0];
        s6_ovf <= 1'b0;
      end
      if (n6 >= 12'd63) s6_dn <= '0;
      else              s6_dn <= 48'(sum_dn >> (7'(n6[5:0]) + 7'd1));
    end
  end

  // stage 7: coefficient products, split on the exponential
  logic [47:0] ep, em;
  logic [55:0] s7_ph, s7_pl, s7_mh, s7_ml;
  logic        s7_ovf;
  assign ep = s6_neg ? s6_dn : s6_up;
  assign em = s6_neg ? s6_up : s6_dn;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_ph  <= 56'(cfg.hi_coef) * 56'(ep[47:24]);
      s7_pl  <= 56'(cfg.hi_coef) * 56'(ep[23:0]);
      s7_mh  <= 56'(cfg.lo_coef) * 56'(em[47:24]);
      s7_ml  <= 56'(cfg.lo_coef) * 56'(em[23:0]);
      s7_ovf <= s6_ovf;
    end
  end

  // stage 8: combine to Q.40
  logic [79:0] m1p_full, m1m_full;
  logic [47:0] s8_p, s8_m;
  logic        s8_ovf;
  assign m1p_full = (80'(s7_ph) << 24) + 80'(s7_pl);
  assign m1m_full = (80'(s7_mh) << 24) + 80'(s7_ml);

  always_ff @(posedge clk) begin
    if (en) begin
      s8_p   <= m1p_full[79:32];
      s8_m   <= m1m_full[79:32];
      s8_ovf <= s7_ovf;
    end
  end

  // stage 9: gain products
  logic [47:0] s9_ph, s9_pl, s9_mh, s9_ml;
  logic        s9_ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_ph  <= 48'(s8_p[47:24]) * 48'(cfg.gain);
      s9_pl  <= 48'(s8_p[23:0])  * 48'(cfg.gain);
      s9_mh  <= 48'(s8_m[47:24]) * 48'(cfg.gain);
      s9_ml  <= 48'(s8_m[23:0])  * 48'(cfg.gain);
      s9_ovf <= s8_ovf;
    end
  end

  // stage 10: combine to Q16.16
  logic [71:0] pp_full, pm_full;
  logic [47:0] s10_pp, s10_pm;
  logic        s10_ovf;
  assign pp_full = (72'(s9_ph) << 24) + 72'(s9_pl);
  assign pm_full = (72'(s9_mh) << 24) + 72'(s9_ml);

  always_ff @(posedge clk) begin
    if (en) begin
      s10_pp  <= pp_full[71:24];
      s10_pm  <= pm_full[71:24];
      s10_ovf <= s9_ovf;
    end
  end

  // stage 11: torque and stiffness sum
  logic signed [48:0] s11_tq;
  logic        [48:0] s11_ss;
  logic               s11_ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      s11_tq  <= $signed({1'b0, s10_pp}) - $signed({1'b0, s10_pm});
      s11_ss  <= 49'(s10_pp) + 49'(s10_pm);
      s11_ovf <= s10_ovf;
    end
  end

  // stage 12: rate products
  logic [48:0] s12_sh;
  logic [47:0] s12_sl;
  logic signed [48:0] s12_tq;
  logic        s12_ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      s12_sh  <= 49'(s11_ss[48:24]) * 49'(cfg.rate);
      s12_sl  <= 48'(s11_ss[23:0])  * 48'(cfg.rate);
      s12_tq  <= s11_tq;
      s12_ovf <= s11_ovf;
    end
  end

  // stage 13: stiffness in Q16.16
  logic [72:0] st_full;
  assign st_full = (73'(s12_sh) << 24) + 73'(s12_sl);

  always_ff @(posedge clk) begin
    if (en) begin
      res.torque    <= s12_tq;
      res.stiffness <= st_full[72:16];
      res.ovf       <= s12_ovf;
    end
  end

endmodule

/* rtl/antagonistic_exp_spring_torque.sv */
// ----------------------------------------------------------------------------
// antagonistic_exp_spring_torque: elastic torques and stiffness of a spring pair
// Two exponential spring lanes, the configuration registers and the output
// stage with saturation.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Every cycle a new sample may enter unless in_stall
// is high; a result leaves the output register after its input beat has passed
// the two stages per Taylor term of the exponential units plus the deflection,
// range reduction and product stages around them. The whole pipe advances
// together: in_stall is high only while a result sits in the output register
// and the sink stalls it, so there is no clearing pass and no warm-up.
// Write configuration only while no beat is in flight.
// ----------------------------------------------------------------------------
module antagonistic_exp_spring_torque (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] motor_one_angle,
  input  logic signed [31:0] motor_two_angle,
  input  logic signed [31:0] link_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] torque_one,
  output logic signed [31:0] torque_two,
  output logic signed [31:0] link_torque,
  output logic signed [31:0] link_stiffness,
  output logic               overflow,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import aest_pkg::*;

  // configuration registers
  logic [31:0] a_coeff, b_coeff;
  logic [23:0] gain, rate;
  logic [26:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_coeff <= 32'd1330409;
      b_coeff <= 32'd2616838;
      gain    <= 24'd160000;
      rate    <= 24'd570819;
      limit   <= 27'd4529848;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_A_COEFF: a_coeff <= cfg_data;
        REG_B_COEFF: b_coeff <= cfg_data;
        REG_GAIN:    gain    <= cfg_data[23:0];
        REG_RATE:    rate    <= cfg_data[23:0];
        REG_LIMIT:   limit   <= cfg_data[26:0];
        default: ;
      endcase
    end
  end

  // advance the pipe unless the finished result is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // the first spring pulls with b on e^x, the second with a on e^y
  spring_cfg_t cfg_one, cfg_two;
  lane_res_t   res_one, res_two;

  assign cfg_one = '{lo_coef: a_coeff, hi_coef: b_coeff, gain: gain,
                     rate: rate, limit: limit};
  assign cfg_two = '{lo_coef: b_coeff, hi_coef: a_coeff, gain: gain,
                     rate: rate, limit: limit};

  aest_spring u_spring_one (
    .clk(clk), .en(en), .motor(motor_one_angle), .link(link_angle),
    .cfg(cfg_one), .res(res_one)
  );

  aest_spring u_spring_two (
    .clk(clk), .en(en), .motor(motor_two_angle), .link(link_angle),
    .cfg(cfg_two), .res(res_two)
  );

  // valid bits ride alongside the lane stages
  logic vld [LANE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LANE_LAT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < LANE_LAT; k++) vld[k] <= vld[k-1];
    end
  end

  // clamp to signed 32 bit; top bit of the result flags saturation
  function automatic logic [32:0] sat32(input logic signed [49:0] v);
    logic [32:0] r;
    if (v > 50'sd2147483647)        r = {1'b1, 32'h7FFF_FFFF};
    else if (v < -50'sd2147483648)  r = {1'b1, 32'h8000_0000};
    else                            r = {1'b0, v[31:0]};
    return r;
  endfunction

  logic [32:0] c_one, c_two, c_link;
  logic [57:0] st_sum;
  logic        st_sat;

  always_comb begin
    c_one  = sat32(50'(res_one.torque));
    c_two  = sat32(50'(res_two.torque));
    c_link = sat32(50'(res_one.torque) + 50'(res_two.torque));
    st_sum = 58'(res_one.stiffness) + 58'(res_two.stiffness);
    st_sat = st_sum > 58'h7FFF_FFFF;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      torque_one     <= c_one[31:0];
      torque_two     <= c_two[31:0];
      link_torque    <= c_link[31:0];
      link_stiffness <= st_sat ? 32'h7FFF_FFFF : st_sum[31:0];
      overflow       <= res_one.ovf | res_two.ovf | c_one[32] | c_two[32] |
                        c_link[32] | st_sat;
    end
  end

`ifndef NO_ASSERTIONS
  // stiffness is a sum of magnitudes and never goes negative
  a_stiff_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !link_stiffness[31])
    else $error("link stiffness negative");

  // without saturation the link torque is the exact sum of both torques
  a_link_sum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !overflow) |-> (link_torque == torque_one + torque_two))
    else $error("link torque differs from torque sum");

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(link_torque)
                                  && $stable(link_stiffness)))
    else $error("stalled result changed");
`endif

endmodule

/* tb/antagonistic_exp_spring_torque_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// antagonistic_exp_spring_torque_tb: self-checking bench for the spring pair
// Drives joint-angle beats through a valid/stall handshake, predicts torques,
// stiffness and the overflow flag in software, and compares every result
// beat in order. Runs several register settings, extremes included.
// ----------------------------------------------------------------------------
module antagonistic_exp_spring_torque_tb;
  import aest_pkg::*;

  localparam longint unsigned LN2_C    = 64'd2977044472;
  localparam longint unsigned ONE_C    = 64'd4294967296;
  localparam longint unsigned EXPSAT_C = 64'd281474976710655;
  localparam longint unsigned CAP_C    = 64'd4611686018427387904;
  localparam int              PIPE_LAT = LANE_LAT + 1;

  typedef struct packed {
    logic signed [31:0] m1;
    logic signed [31:0] m2;
    logic signed [31:0] lk;
  } angles_t;

  typedef struct packed {
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] tl;
    logic signed [31:0] st;
    logic               ovf;
  } torques_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] motor_one_angle, motor_two_angle, link_angle;
  logic signed [31:0] torque_one, torque_two, link_torque, link_stiffness;
  logic overflow;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  antagonistic_exp_spring_torque dut (.*);

  // predictor copy of the register file
  longint unsigned coef_a, coef_b, gain_k, rate_ke, def_lim;

  angles_t  pending_beats[$];
  torques_t expected_torques[$];
  int errors;
  int src_idle_pct, snk_idle_pct;
  bit hold_src;
  bit in_taken;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // floor(x*y >> sh), capped at 2^62
  function automatic longint unsigned mul_shift(longint unsigned x, longint unsigned y,
                                                int sh, ref bit ovf);
    logic [127:0] p;
    p = ({64'd0, x} * {64'd0, y}) >> sh;
    if (p > {64'd0, CAP_C}) begin
      ovf = 1'b1;
      return CAP_C;
    end
    return p[63:0];
  endfunction

  function automatic longint unsigned taylor_exp(longint unsigned r);
    longint unsigned term, sum;
    term = ONE_C;
    sum = ONE_C;
    for (int i = 1; i <= TAYLOR_TERMS; i++) begin
      term = ((term * r) >> 32) / i;
      sum += term;
    end
    return sum;
  endfunction

  function automatic void exp_both(longint unsigned m, output longint unsigned up,
                                   output longint unsigned dn, ref bit ovf);
    longint unsigned n, r, v;
    n = m / LN2_C;
    r = m - n * LN2_C;
    if (n >= 16) begin
      up = EXPSAT_C;
      ovf = 1'b1;
    end else begin
      v = taylor_exp(r) << n;
      if (v > EXPSAT_C) begin
        v = EXPSAT_C;
        ovf = 1'b1;
      end
      up = v;
    end
    dn = (n + 1 >= 64) ? 0 : (taylor_exp(LN2_C - r) >> (n + 1));
  endfunction

  function automatic void spring_lane(longint d, longint unsigned lo_c,
                                      longint unsigned hi_c, output longint t,
                                      output longint unsigned s, ref bit ovf);
    longint lim;
    longint unsigned mag, eup, edn, ep, em, pp, pm;
    lim = longint'(def_lim);
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    mag = (d < 0) ? longint'(-d) : d;
    exp_both((mag * rate_ke) >> 8, eup, edn, ovf);
    if (d >= 0) begin
      ep = eup; em = edn;
    end else begin
      ep = edn; em = eup;
    end
    pp = mul_shift(mul_shift(hi_c, ep, 32, ovf), gain_k, 24, ovf);
    pm = mul_shift(mul_shift(lo_c, em, 32, ovf), gain_k, 24, ovf);
    t = longint'(pp) - longint'(pm);
    s = mul_shift(pp + pm, rate_ke, 16, ovf);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic torques_t predict_torques(angles_t a);
    torques_t r;
    bit ovf;
    longint t1, t2;
    longint unsigned s1, s2, st;
    ovf = 1'b0;
    spring_lane(longint'(a.m1) - longint'(a.lk), coef_a, coef_b, t1, s1, ovf);
    spring_lane(longint'(a.m2) - longint'(a.lk), coef_b, coef_a, t2, s2, ovf);
    st = s1 + s2;
    r.t1 = clamp32(t1, ovf);
    r.t2 = clamp32(t2, ovf);
    r.tl = clamp32(t1 + t2, ovf);
    if (st > 64'h7FFFFFFF) begin
      ovf = 1'b1;
      st = 64'h7FFFFFFF;
    end
    r.st = st[31:0];
    r.ovf = ovf;
    return r;
  endfunction

  // Input acceptance: record the beat taken at this rising edge and predict it.
  always @(posedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) begin
      expected_torques.push_back(predict_torques(pending_beats.pop_front()));
    end
  end

  // Driver: present the head of the queue at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // Advance only when the current beat was taken or none is shown.
      if (!in_valid || in_taken) begin
        if (pending_beats.size() > 0 && !hold_src &&
            $urandom_range(99) >= src_idle_pct) begin
          in_valid        <= 1'b1;
          motor_one_angle <= pending_beats[0].m1;
          motor_two_angle <= pending_beats[0].m2;
          link_angle      <= pending_beats[0].lk;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  // Monitor: compare each taken result beat with the oldest expectation.
  always @(posedge clk) begin
    torques_t exp_t;
    if (!rst && out_valid && !out_stall) begin
      if (expected_torques.size() == 0) begin
        $display("%0t: unexpected result beat t1=%0d", $time, torque_one);
        errors++;
      end else begin
        exp_t = expected_torques.pop_front();
        if (torque_one !== exp_t.t1) begin
          $display("%0t: torque_one exp %0d got %0d", $time, exp_t.t1, torque_one);
          errors++;
        end
        if (torque_two !== exp_t.t2) begin
          $display("%0t: torque_two exp %0d got %0d", $time, exp_t.t2, torque_two);
          errors++;
        end
        if (link_torque !== exp_t.tl) begin
          $display("%0t: link_torque exp %0d got %0d", $time, exp_t.tl, link_torque);
          errors++;
        end
        if (link_stiffness !== exp_t.st) begin
          $display("%0t: link_stiffness exp %0d got %0d", $time, exp_t.st,
                   link_stiffness);
          errors++;
        end
        if (overflow !== exp_t.ovf) begin
          $display("%0t: overflow exp %0b got %0b", $time, exp_t.ovf, overflow);
          errors++;
        end
      end
    end
  end

  // Write one register on the falling edge; mirror it into the predictor.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_A_COEFF: coef_a  = val;
      REG_B_COEFF: coef_b  = val;
      REG_GAIN:    gain_k  = val[23:0];
      REG_RATE:    rate_ke = val[23:0];
      REG_LIMIT:   def_lim = val[26:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !in_valid && expected_torques.size() == 0);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_angle();
    case ($urandom_range(3))
      0: return $urandom;                               // anything
      1: return $signed($urandom_range(16'hFFFF)) - 32'sd32768;  // near zero
      2: return $signed($urandom) >>> $urandom_range(31);
      default: return $signed($urandom_range(32'h0FFFFFFF)) - 32'sh08000000;
    endcase
  endfunction

  // Mostly joint angles around the link so deflections sit near the active range.
  task automatic push_random(int n);
    angles_t a;
    repeat (n) begin
      a.lk = rand_angle();
      if ($urandom_range(3) != 0) begin
        a.m1 = a.lk + ($signed($urandom_range(32'h01FFFFFF)) - 32'sh01000000);
        a.m2 = a.lk + ($signed($urandom_range(32'h01FFFFFF)) - 32'sh01000000);
      end else begin
        a.m1 = rand_angle();
        a.m2 = rand_angle();
      end
      pending_beats.push_back(a);
    end
  endtask

  task automatic push_beat(logic [31:0] m1, logic [31:0] m2, logic [31:0] lk);
    angles_t a;
    a.m1 = m1; a.m2 = m2; a.lk = lk;
    pending_beats.push_back(a);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    motor_one_angle = '0;
    motor_two_angle = '0;
    link_angle = '0;
    cfg_write = 1'b0;
    cfg_index = REG_A_COEFF;
    cfg_data = '0;
    errors = 0;
    hold_src = 1'b0;
    src_idle_pct = 8;
    snk_idle_pct = 72;
    // reset register values
    coef_a = 1330409; coef_b = 2616838; gain_k = 160000;
    rate_ke = 570819; def_lim = 4529848;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes and clamp edges at reset settings.
    push_beat(0, 0, 0);
    push_beat(32'h7FFFFFFF, 32'h80000000, 0);
    push_beat(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    push_beat(0, 0, 32'h7FFFFFFF);
    push_beat(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    push_beat(32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    push_beat(4529848, -4529848, 0);
    push_beat(4529849, -4529849, 0);
    push_beat(32'hFFFFFFFF, 1, 0);
    push_beat(32'h55555555, 32'hAAAAAAAA, 32'h33333333);
    drain();

    // Hold the sender while beats queue up, then release it.
    hold_src = 1'b1;
    push_random(20);
    repeat (30) @(negedge clk);
    hold_src = 1'b0;
    drain();

    // Full-scale registers: saturation everywhere.
    write_reg(REG_A_COEFF, 32'hFFFFFFFF);
    write_reg(REG_B_COEFF, 32'hFFFFFFFF);
    write_reg(REG_GAIN, 32'hFFFFFFFF);
    write_reg(REG_RATE, 32'hFFFFFFFF);
    write_reg(REG_LIMIT, 32'hFFFFFFFF);
    push_beat(32'h7FFFFFFF, 32'h80000000, 0);
    push_beat(0, 0, 0);
    push_random(100);
    drain();

    // Zero gain, rate, limit and coefficients: everything collapses to zero.
    write_reg(REG_GAIN, 0);
    write_reg(REG_RATE, 0);
    write_reg(REG_LIMIT, 0);
    write_reg(REG_A_COEFF, 0);
    write_reg(REG_B_COEFF, 0);
    write_reg(3'd7, 32'hDEADBEEF);   // unknown index, must be ignored
    push_beat(32'h7FFFFFFF, 32'h80000000, 1);
    push_random(40);
    drain();

    // Swap idling pattern, random mid-range settings.
    src_idle_pct = 72;
    snk_idle_pct = 8;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_A_COEFF, $urandom);
      write_reg(REG_B_COEFF, $urandom >> $urandom_range(16));
      write_reg(REG_GAIN, $urandom >> $urandom_range(20));
      write_reg(REG_RATE, $urandom >> $urandom_range(16));
      write_reg(REG_LIMIT, $urandom >> $urandom_range(10));
      push_random(200);
      drain();
    end

    // No idling, back to reset-like settings.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(REG_A_COEFF, 1330409);
    write_reg(REG_B_COEFF, 2616838);
    write_reg(REG_GAIN, 160000);
    write_reg(REG_RATE, 570819);
    write_reg(REG_LIMIT, 4529848);
    push_random(900);
    drain();

    if (errors == 0) begin
      $display("antagonistic_exp_spring_torque_tb passed");
    end else begin
      $display("antagonistic_exp_spring_torque_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("antagonistic_exp_spring_torque_tb failed");
    $finish;
  end

endmodule
